>>> rtl/core/tun_pkg.sv
package tun_pkg;

   // Default coordinate width in bits (signed 20.12 meters).
   localparam int COORD_BITS_DEF = 32;

   // Port field widths.
   localparam int IDX_W      = 16;
   localparam int IN_W       = 32;
   localparam int MIN_AREA_W = 40;
   localparam int NORM_W     = 14;

   // Reset value of the area threshold, which is 1e-8 * 2^48.
   localparam logic [MIN_AREA_W-1:0] MIN_AREA_RST = 40'd2814750;

   // Unit length of the normal and the bits of the magnitude search.
   localparam int K_W       = 13;
   localparam int FRAC_BITS = 12;
   localparam logic [K_W-1:0] UNIT_ONE = 13'd4096;

endpackage

>>> rtl/core/tun_cross.sv
module tun_cross #(
   parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [tun_pkg::IDX_W-1:0]         idx_a,
   input  logic [tun_pkg::IDX_W-1:0]         idx_b,
   input  logic [tun_pkg::IDX_W-1:0]         idx_c,
   input  logic [COORD_BITS-1:0]             pos_a [3],
   input  logic [COORD_BITS-1:0]             pos_b [3],
   input  logic [COORD_BITS-1:0]             pos_c [3],
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic                              dup,
   output logic signed [2*COORD_BITS+2:0]    n_vec [3]
);

   localparam int D  = COORD_BITS + 1;
   localparam int P  = 2 * D;
   localparam int NW = P + 1;
   localparam int NS = 3;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   ce;

   logic signed [D-1:0]  u_in [3], v_in [3], u_ff [3], v_ff [3];
   logic signed [P-1:0]  prod_in [6], prod_ff [6];
   logic signed [NW-1:0] n_in [3], n_ff [3];
   logic                 dup1_in, dup1_ff, dup2_ff, dup3_ff;

   // A stage takes a new item when it is empty or when the next one moves.
   assign ce[NS] = out_ready;
   for (genvar g = 0; g < NS; g++) begin : g_ce
      assign ce[g] = !vld_ff[g] || ce[g+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (ce[0]) vld_ff[0] <= in_valid;
         if (ce[1]) vld_ff[1] <= vld_ff[0];
         if (ce[2]) vld_ff[2] <= vld_ff[1];
      end
   end

   // Edge vectors from corner a, and the repeated index test.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u_in[i] = $signed({pos_b[i][COORD_BITS-1], pos_b[i]})
                 - $signed({pos_a[i][COORD_BITS-1], pos_a[i]});
         v_in[i] = $signed({pos_c[i][COORD_BITS-1], pos_c[i]})
                 - $signed({pos_a[i][COORD_BITS-1], pos_a[i]});
      end
      dup1_in = (idx_a == idx_b) || (idx_b == idx_c) || (idx_a == idx_c);
   end

   // The six partial products of the cross product.
   always_comb begin
      prod_in[0] = u_ff[1] * v_ff[2];
      prod_in[1] = u_ff[2] * v_ff[1];
      prod_in[2] = u_ff[2] * v_ff[0];
      prod_in[3] = u_ff[0] * v_ff[2];
      prod_in[4] = u_ff[0] * v_ff[1];
      prod_in[5] = u_ff[1] * v_ff[0];
   end

   // Cross product components.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = NW'(prod_ff[2*i]) - NW'(prod_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (ce[0]) begin
         u_ff    <= u_in;
         v_ff    <= v_in;
         dup1_ff <= dup1_in;
      end
      if (ce[1]) begin
         prod_ff <= prod_in;
         dup2_ff <= dup1_ff;
      end
      if (ce[2]) begin
         n_ff    <= n_in;
         dup3_ff <= dup2_ff;
      end
   end

   assign in_ready  = ce[0];
   assign out_valid = vld_ff[NS-1];
   assign dup       = dup3_ff;
   assign n_vec     = n_ff;

endmodule

>>> rtl/core/tun_square.sv
module tun_square #(
   parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic                                dup,
   input  logic signed [2*COORD_BITS+2:0]      n_vec [3],
   input  logic [tun_pkg::MIN_AREA_W-1:0]      min_area,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [4*COORD_BITS+5:0]             s_sum,
   output logic [4*COORD_BITS+3:0]             m_sq [3],
   output logic [2:0]                          neg,
   output logic                                kill
);

   localparam int NW = 2 * COORD_BITS + 3;
   localparam int M  = NW - 1;
   localparam int L  = M / 2;
   localparam int H  = M - L;
   localparam int Q  = 2 * M;
   localparam int SW = Q + 2;
   localparam int NS = 5;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   ce;

   logic [M-1:0]     mag_in [3], mag_ff [3];
   logic [2*L-1:0]   pll_in [3], pll_ff [3];
   logic [M-1:0]     plh_in [3], plh_ff [3];
   logic [2*H-1:0]   phh_in [3], phh_ff [3];
   logic [Q-1:0]     sq_in [3], sq_ff [3], sq4_ff [3], sq5_ff [3];
   logic [SW-1:0]    s_in, s4_ff, s5_ff;
   logic [2:0]       neg_in, neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff;
   logic             dup1_ff, dup2_ff, dup3_ff, dup4_ff;
   logic             kill_in, kill_ff;

   assign ce[NS] = out_ready;
   for (genvar g = 0; g < NS; g++) begin : g_ce
      assign ce[g] = !vld_ff[g] || ce[g+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (ce[0]) vld_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) begin
            if (ce[i]) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // Sign and magnitude of each component.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = n_vec[i][NW-1];
         mag_in[i] = n_vec[i][NW-1] ? M'(NW'(0) - n_vec[i]) : M'(n_vec[i]);
      end
   end

   // Squares split into half-width partial products.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pll_in[i] = mag_ff[i][L-1:0] * mag_ff[i][L-1:0];
         plh_in[i] = mag_ff[i][M-1:L] * mag_ff[i][L-1:0];
         phh_in[i] = mag_ff[i][M-1:L] * mag_ff[i][M-1:L];
      end
   end

   // Partial products recombined into full squares.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (Q'(phh_ff[i]) << (2*L)) + (Q'(plh_ff[i]) << (L+1)) + Q'(pll_ff[i]);
      end
   end

   // Squared length and the degenerate test.
   assign s_in    = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
   assign kill_in = dup4_ff || (s4_ff == '0) || (s4_ff < SW'(min_area));

   always_ff @(posedge clock) begin
      if (ce[0]) begin
         mag_ff  <= mag_in;
         neg1_ff <= neg_in;
         dup1_ff <= dup;
      end
      if (ce[1]) begin
         pll_ff  <= pll_in;
         plh_ff  <= plh_in;
         phh_ff  <= phh_in;
         neg2_ff <= neg1_ff;
         dup2_ff <= dup1_ff;
      end
      if (ce[2]) begin
         sq_ff   <= sq_in;
         neg3_ff <= neg2_ff;
         dup3_ff <= dup2_ff;
      end
      if (ce[3]) begin
         s4_ff   <= s_in;
         sq4_ff  <= sq_ff;
         neg4_ff <= neg3_ff;
         dup4_ff <= dup3_ff;
      end
      if (ce[4]) begin
         s5_ff   <= s4_ff;
         sq5_ff  <= sq4_ff;
         neg5_ff <= neg4_ff;
         kill_ff <= kill_in;
      end
   end

   assign in_ready  = ce[0];
   assign out_valid = vld_ff[NS-1];
   assign s_sum     = s5_ff;
   assign m_sq      = sq5_ff;
   assign neg       = neg5_ff;
   assign kill      = kill_ff;

endmodule

>>> rtl/core/tun_root.sv
module tun_root #(
   parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic [4*COORD_BITS+5:0]                 s_sum,
   input  logic [4*COORD_BITS+3:0]                 m_sq [3],
   input  logic [2:0]                              neg,
   input  logic                                    kill,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic                                    kept,
   output logic signed [tun_pkg::NORM_W-1:0]       normal [3]
);

   localparam int Q   = 4 * COORD_BITS + 4;
   localparam int SW  = Q + 2;
   localparam int CW  = SW + 28;
   localparam int KW  = tun_pkg::K_W;
   localparam int NS  = KW;
   localparam int NT  = NS + 2;
   localparam int SH  = 2 * tun_pkg::FRAC_BITS;

   logic [NT-1:0] vld_ff;
   logic [NT:0]   ce;

   // Search stage registers: k, k^2*S and k*S per component.
   logic [KW-1:0] k_ff   [NS][3];
   logic [CW-1:0] k2s_ff [NS][3];
   logic [CW-1:0] ks_ff  [NS][3];
   logic [SW-1:0] s_ff   [NS];
   logic [Q-1:0]  m2_ff  [NS][3];
   logic [2:0]    neg_ff [NS];
   logic          kill_ff [NS];

   logic [KW-1:0] rk_in [3], rk_ff [3];
   logic [2:0]    rneg_ff;
   logic          rkill_ff;

   logic signed [tun_pkg::NORM_W-1:0] nrm_in [3], nrm_ff [3];
   logic                              kept_ff;

   assign ce[NT] = out_ready;
   for (genvar g = 0; g < NT; g++) begin : g_ce
      assign ce[g] = !vld_ff[g] || ce[g+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (ce[0]) vld_ff[0] <= in_valid;
         for (int i = 1; i < NT; i++) begin
            if (ce[i]) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // One result bit per stage, most significant first. The trial square
   // (k + 2^b)^2 * S is built from the running k^2*S and k*S by shifts and adds.
   for (genvar j = 0; j < NS; j++) begin : g_bit
      localparam int B = NS - 1 - j;

      logic [KW-1:0] k_src [3];
      logic [CW-1:0] k2s_src [3], ks_src [3];
      logic [SW-1:0] s_src;
      logic [Q-1:0]  m2_src [3];
      logic [2:0]    neg_src;
      logic          kill_src;
      logic [KW-1:0] tr [3];
      logic [CW-1:0] t2s [3];
      logic          take [3];
      logic [KW-1:0] k_in [3];
      logic [CW-1:0] k2s_in [3], ks_in [3];

      if (j == 0) begin : g_first
         assign k_src    = '{default: '0};
         assign k2s_src  = '{default: '0};
         assign ks_src   = '{default: '0};
         assign s_src    = s_sum;
         assign m2_src   = m_sq;
         assign neg_src  = neg;
         assign kill_src = kill;
      end else begin : g_next
         assign k_src    = k_ff[j-1];
         assign k2s_src  = k2s_ff[j-1];
         assign ks_src   = ks_ff[j-1];
         assign s_src    = s_ff[j-1];
         assign m2_src   = m2_ff[j-1];
         assign neg_src  = neg_ff[j-1];
         assign kill_src = kill_ff[j-1];
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            tr[i]  = k_src[i] | (KW'(1) << B);
            t2s[i] = k2s_src[i] + (ks_src[i] << (B + 1)) + (CW'(s_src) << (2 * B));
            take[i] = (tr[i] <= tun_pkg::UNIT_ONE) && (t2s[i] <= (CW'(m2_src[i]) << SH));
            k_in[i]   = take[i] ? tr[i] : k_src[i];
            k2s_in[i] = take[i] ? t2s[i] : k2s_src[i];
            ks_in[i]  = take[i] ? (ks_src[i] + (CW'(s_src) << B)) : ks_src[i];
         end
      end

      always_ff @(posedge clock) begin
         if (ce[j]) begin
            k_ff[j]    <= k_in;
            k2s_ff[j]  <= k2s_in;
            ks_ff[j]   <= ks_in;
            s_ff[j]    <= s_src;
            m2_ff[j]   <= m2_src;
            neg_ff[j]  <= neg_src;
            kill_ff[j] <= kill_src;
         end
      end
   end

   // Round to nearest, ties to even: compare (2k+1)^2 * S against 4 * target.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [CW-1:0] odd_s, half;
         odd_s = (k2s_ff[NS-1][i] << 2) + (ks_ff[NS-1][i] << 2) + CW'(s_ff[NS-1]);
         half  = CW'(m2_ff[NS-1][i]) << (SH + 2);
         if ((odd_s < half) || ((odd_s == half) && k_ff[NS-1][i][0])) begin
            rk_in[i] = k_ff[NS-1][i] + KW'(1);
         end else begin
            rk_in[i] = k_ff[NS-1][i];
         end
      end
   end

   // Sign restored; a degenerate triangle reports a zero normal.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (rkill_ff) begin
            nrm_in[i] = '0;
         end else if (rneg_ff[i]) begin
            nrm_in[i] = -$signed(tun_pkg::NORM_W'(rk_ff[i]));
         end else begin
            nrm_in[i] = $signed(tun_pkg::NORM_W'(rk_ff[i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce[NS]) begin
         rk_ff    <= rk_in;
         rneg_ff  <= neg_ff[NS-1];
         rkill_ff <= kill_ff[NS-1];
      end
      if (ce[NS+1]) begin
         nrm_ff  <= nrm_in;
         kept_ff <= !rkill_ff;
      end
   end

   assign in_ready  = ce[0];
   assign out_valid = vld_ff[NT-1];
   assign kept      = kept_ff;
   assign normal    = nrm_ff;

endmodule

>>> rtl/core/triangle_unit_normal.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  three indices, nine corner coordinates
// rsp       out        rsp_valid/rsp_stall  kept, normal_x, normal_y, normal_z
// csr       in         csr_valid/csr_ready  min_area_sq
//
// One triangle can enter every cycle while no stage is held; each result passes the
// cross product, the squaring and the 13-stage magnitude search, one result bit per stage.
// Reset clears all valid bits and loads the default area threshold.
// A stall on rsp holds the output; earlier stages keep filling empty slots,
// and req_stall rises only once every stage holds an item.
module triangle_unit_normal #(
   parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [tun_pkg::IDX_W-1:0]          req_index_a,
   input  logic [tun_pkg::IDX_W-1:0]          req_index_b,
   input  logic [tun_pkg::IDX_W-1:0]          req_index_c,
   input  logic signed [tun_pkg::IN_W-1:0]    req_ax,
   input  logic signed [tun_pkg::IN_W-1:0]    req_ay,
   input  logic signed [tun_pkg::IN_W-1:0]    req_az,
   input  logic signed [tun_pkg::IN_W-1:0]    req_bx,
   input  logic signed [tun_pkg::IN_W-1:0]    req_by_coord,
   input  logic signed [tun_pkg::IN_W-1:0]    req_bz,
   input  logic signed [tun_pkg::IN_W-1:0]    req_cx,
   input  logic signed [tun_pkg::IN_W-1:0]    req_cy,
   input  logic signed [tun_pkg::IN_W-1:0]    req_cz,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_kept,
   output logic signed [tun_pkg::NORM_W-1:0]  rsp_normal_x,
   output logic signed [tun_pkg::NORM_W-1:0]  rsp_normal_y,
   output logic signed [tun_pkg::NORM_W-1:0]  rsp_normal_z,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tun_pkg::MIN_AREA_W-1:0]     csr_min_area_sq
);

   localparam int NW = 2 * COORD_BITS + 3;
   localparam int Q  = 4 * COORD_BITS + 4;
   localparam int SW = Q + 2;

   logic [tun_pkg::MIN_AREA_W-1:0] min_area_ff;

   logic [COORD_BITS-1:0]           pos_a [3], pos_b [3], pos_c [3];
   logic                            cr_ready, cr_valid, cr_dup;
   logic signed [NW-1:0]            cr_n [3];
   logic                            sq_ready, sq_valid, sq_kill;
   logic [SW-1:0]                   sq_s;
   logic [Q-1:0]                    sq_m2 [3];
   logic [2:0]                      sq_neg;
   logic                            rt_ready;
   logic signed [tun_pkg::NORM_W-1:0] rt_normal [3];

   // Threshold register; every write transfer is taken at once.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_area_ff <= tun_pkg::MIN_AREA_RST;
      end else if (csr_valid && csr_ready) begin
         min_area_ff <= csr_min_area_sq;
      end
   end

   // Only the low coordinate bits are used.
   assign pos_a[0] = req_ax[COORD_BITS-1:0];
   assign pos_a[1] = req_ay[COORD_BITS-1:0];
   assign pos_a[2] = req_az[COORD_BITS-1:0];
   assign pos_b[0] = req_bx[COORD_BITS-1:0];
   assign pos_b[1] = req_by_coord[COORD_BITS-1:0];
   assign pos_b[2] = req_bz[COORD_BITS-1:0];
   assign pos_c[0] = req_cx[COORD_BITS-1:0];
   assign pos_c[1] = req_cy[COORD_BITS-1:0];
   assign pos_c[2] = req_cz[COORD_BITS-1:0];

   assign req_stall = !cr_ready;

   tun_cross #(.COORD_BITS(COORD_BITS)) u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (cr_ready),
      .idx_a     (req_index_a),
      .idx_b     (req_index_b),
      .idx_c     (req_index_c),
      .pos_a     (pos_a),
      .pos_b     (pos_b),
      .pos_c     (pos_c),
      .out_valid (cr_valid),
      .out_ready (sq_ready),
      .dup       (cr_dup),
      .n_vec     (cr_n)
   );

   tun_square #(.COORD_BITS(COORD_BITS)) u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cr_valid),
      .in_ready  (sq_ready),
      .dup       (cr_dup),
      .n_vec     (cr_n),
      .min_area  (min_area_ff),
      .out_valid (sq_valid),
      .out_ready (rt_ready),
      .s_sum     (sq_s),
      .m_sq      (sq_m2),
      .neg       (sq_neg),
      .kill      (sq_kill)
   );

   tun_root #(.COORD_BITS(COORD_BITS)) u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (rt_ready),
      .s_sum     (sq_s),
      .m_sq      (sq_m2),
      .neg       (sq_neg),
      .kill      (sq_kill),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .kept      (rsp_kept),
      .normal    (rt_normal)
   );

   assign rsp_normal_x = rt_normal[0];
   assign rsp_normal_y = rt_normal[1];
   assign rsp_normal_z = rt_normal[2];

endmodule

>>> verif/triangle_unit_normal_test.sv
module triangle_unit_normal_test;

   typedef struct packed {
      logic [tun_pkg::IDX_W-1:0] ia, ib, ic;
      logic signed [tun_pkg::IN_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
   } tri_type;

   typedef struct packed {
      logic kept;
      logic signed [tun_pkg::NORM_W-1:0] nx, ny, nz;
   } norm_type;

   // Directed stimulus row: a triangle and, where obvious, its known result.
   typedef struct {
      tri_type  t;
      bit       known;
      norm_type res;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   tri_type req_t = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_kept;
   logic signed [tun_pkg::NORM_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic csr_valid = 0;
   logic csr_ready;
   logic [tun_pkg::MIN_AREA_W-1:0] csr_min_area_sq = '0;

   logic [tun_pkg::MIN_AREA_W-1:0] area_floor;
   norm_type expected_normals[$];
   int fail_count = 0;
   bit idle_free = 0;

   triangle_unit_normal dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_index_a(req_t.ia), .req_index_b(req_t.ib), .req_index_c(req_t.ic),
      .req_ax(req_t.ax), .req_ay(req_t.ay), .req_az(req_t.az),
      .req_bx(req_t.bx), .req_by_coord(req_t.by), .req_bz(req_t.bz),
      .req_cx(req_t.cx), .req_cy(req_t.cy), .req_cz(req_t.cz),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kept(rsp_kept),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_min_area_sq(csr_min_area_sq)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("triangle_unit_normal test failed");
      $finish;
   end

   // One component: round(4096*|c|/sqrt(s)), ties to even, sign of c restored.
   function automatic logic signed [tun_pkg::NORM_W-1:0] unit_comp(
      logic signed [127:0] c, logic [191:0] s);
      logic [127:0] mag;
      logic [383:0] target, half, lhs;
      logic [13:0] k, tr;
      logic [27:0] odd;
      mag = c[127] ? -c : c;
      target = ({256'd0, mag} * {256'd0, mag}) << 24;
      half = ({256'd0, mag} * {256'd0, mag}) << 26;
      k = '0;
      for (int b = 12; b >= 0; b--) begin
         tr = k | (14'd1 << b);
         if (tr <= 14'd4096) begin
            lhs = {370'd0, tr} * {370'd0, tr} * {192'd0, s};
            if (lhs <= target) k = tr;
         end
      end
      odd = {13'd0, k, 1'b1};
      lhs = {356'd0, odd} * {356'd0, odd} * {192'd0, s};
      if (lhs < half || (lhs == half && k[0])) k = k + 14'd1;
      return c[127] ? -$signed(k) : $signed(k);
   endfunction

   function automatic norm_type face_normal(tri_type t);
      logic signed [127:0] ux, uy, uz, vx, vy, vz, nx, ny, nz;
      logic [191:0] s;
      norm_type r;
      ux = t.bx - t.ax; uy = t.by - t.ay; uz = t.bz - t.az;
      vx = t.cx - t.ax; vy = t.cy - t.ay; vz = t.cz - t.az;
      nx = uy * vz - uz * vy;
      ny = uz * vx - ux * vz;
      nz = ux * vy - uy * vx;
      s = {{64{nx[127]}}, nx} * {{64{nx[127]}}, nx}
        + {{64{ny[127]}}, ny} * {{64{ny[127]}}, ny}
        + {{64{nz[127]}}, nz} * {{64{nz[127]}}, nz};
      r = '0;
      if (t.ia == t.ib || t.ib == t.ic || t.ia == t.ic) return r;
      if (s == 0 || s < {152'd0, area_floor}) return r;
      r.kept = 1;
      r.nx = unit_comp(nx, s);
      r.ny = unit_comp(ny, s);
      r.nz = unit_comp(nz, s);
      return r;
   endfunction

   // Result side: random stalls, and compare each transfer with the oldest expectation.
   always @(posedge clock) begin
      norm_type got, want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_kept, rsp_normal_x, rsp_normal_y, rsp_normal_z};
            if (expected_normals.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               fail_count++;
            end else begin
               want = expected_normals.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected kept=%0d n=(%0d,%0d,%0d)",
                     $time, want.kept, want.nx, want.ny, want.nz);
                  $display("%0t:          actual kept=%0d n=(%0d,%0d,%0d)",
                     $time, got.kept, got.nx, got.ny, got.nz);
                  fail_count++;
               end
            end
         end
         rsp_stall <= !idle_free && ($urandom_range(99) < 16);
      end
   end

   // Sends one triangle, with a random idle gap first, and waits for its transfer.
   task automatic send_tri(tri_type t);
      while (!idle_free && $urandom_range(99) < 16) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_t <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_normals.insert(expected_normals.size(), face_normal(t));
   endtask

   task automatic write_floor(logic [tun_pkg::MIN_AREA_W-1:0] v);
      csr_valid <= 1;
      csr_min_area_sq <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      area_floor = v;
   endtask

   task automatic drain;
      req_valid <= 0;
      while (expected_normals.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(8191) - 4096;
         default: return 32'h1000 * ($urandom_range(6) - 3);
      endcase
   endfunction

   function automatic tri_type rand_tri();
      tri_type t;
      int mode;
      mode = $urandom_range(2);
      t.ia = 16'($urandom); t.ib = 16'($urandom); t.ic = 16'($urandom);
      if ($urandom_range(9) == 0) t.ib = t.ia;
      if ($urandom_range(9) == 0) t.ic = t.ib;
      t.ax = rand_coord(mode); t.ay = rand_coord(mode); t.az = rand_coord(mode);
      t.bx = rand_coord(mode); t.by = rand_coord(mode); t.bz = rand_coord(mode);
      t.cx = rand_coord(mode); t.cy = rand_coord(mode); t.cz = rand_coord(mode);
      // Sometimes make the corners collinear.
      if ($urandom_range(19) == 0) begin
         t.cx = 2 * t.bx - t.ax; t.cy = 2 * t.by - t.ay; t.cz = 2 * t.bz - t.az;
      end
      return t;
   endfunction

   localparam logic [31:0] MX = 32'h7FFF_FFFF;
   localparam logic [31:0] MN = 32'h8000_0000;
   localparam logic [31:0] ONE = 32'h1000;

   row_type rows[$];

   task automatic add_row(tri_type t, bit known, norm_type res);
      row_type r;
      r.t = t;
      r.known = known;
      r.res = res;
      rows.insert(rows.size(), r);
   endtask

   initial begin
      norm_type zero_n, z_up;
      logic [tun_pkg::MIN_AREA_W-1:0] floors[4];
      zero_n = '0;
      z_up = {1'b1, 14'sd0, 14'sd0, 14'sd4096};
      // Directed table: unit triangle in xy gives +z, repeated indices, zero area,
      // extremes of the coordinates and indices.
      add_row('{0, 1, 2, 0, 0, 0, ONE, 0, 0, 0, ONE, 0}, 1, z_up);
      add_row('{5, 5, 2, 0, 0, 0, ONE, 0, 0, 0, ONE, 0}, 1, zero_n);
      add_row('{5, 2, 2, 0, 0, 0, ONE, 0, 0, 0, ONE, 0}, 1, zero_n);
      add_row('{7, 2, 7, 0, 0, 0, ONE, 0, 0, 0, ONE, 0}, 1, zero_n);
      add_row('{0, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, zero_n);
      add_row('{0, 1, 2, 0, 0, 0, 1, 0, 0, 0, 1, 0}, 1, zero_n);
      add_row('{16'hFFFF, 0, 1, 0, 0, 0, 0, ONE, 0, 0, 0, ONE}, 0, zero_n);
      add_row('{1, 16'hFFFF, 0, MX, MX, MX, MN, MN, MN, MX, MN, MX}, 0, zero_n);
      add_row('{2, 3, 16'hFFFF, MN, MX, MN, MX, MN, MX, MN, MN, MX}, 0, zero_n);
      add_row('{3, 4, 5, MX, MX, MX, MX, MX, MX, MX, MX, MX}, 1, zero_n);
      add_row('{3, 4, 5, MN, 0, 0, MX, 0, 0, MN, MX, 0}, 0, zero_n);
      add_row('{9, 8, 6, 0, 0, 0, ONE, ONE, 0, 2 * ONE, 2 * ONE, 0}, 1, zero_n);
      add_row('{9, 8, 6, 0, 0, 0, ONE, 0, 0, 0, 0, ONE}, 0, zero_n);
      add_row('{9, 8, 6, 0, 0, 0, 3 * ONE, ONE, 0, 0, 0, ONE}, 0, zero_n);
      add_row('{9, 8, 6, -1, -1, -1, ONE, 2 * ONE, 0, 0, 0, 5}, 0, zero_n);

      repeat (7) @(posedge clock);
      reset <= 0;
      area_floor = tun_pkg::MIN_AREA_RST;

      // Directed rows at the reset threshold.
      foreach (rows[i]) begin
         if (rows[i].known && face_normal(rows[i].t) !== rows[i].res) begin
            $display("%0t: directed row %0d expected %h actual %h", $time, i,
               rows[i].res, face_normal(rows[i].t));
            fail_count++;
         end
         send_tri(rows[i].t);
      end
      drain();

      // Random phases over several thresholds, extremes included.
      floors[0] = '0;
      floors[1] = '1;
      floors[2] = 40'd16777216;
      floors[3] = tun_pkg::MIN_AREA_RST;
      for (int ph = 0; ph < 4; ph++) begin
         write_floor(floors[ph]);
         for (int n = 0; n < 115; n++) begin
            idle_free = (ph == 2);
            send_tri(rand_tri());
         end
         idle_free = 0;
         drain();
      end

      if (fail_count == 0) $display("triangle_unit_normal test passed");
      else $display("triangle_unit_normal test failed");
      $finish;
   end

endmodule
